FILE: hw/rtl/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg: shared constants and types of the shortest-path block
// Sizes, operation codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bfsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 128;
  localparam int WEIGHT_BITS  = 16;

  localparam int VTX_W   = 7;                       // vertex field width
  localparam int WT_W    = 16;                      // weight port width
  localparam int DIST_W  = 32;
  localparam int VDEPTH  = MAX_VERTICES + 1;        // vertex 0 unused
  localparam int EA_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
  localparam int EDGE_W  = 2 * VTX_W + WEIGHT_BITS;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic load_edge;    // store edge, post add status
    logic clear_edges;  // empty edge list, post zero result
    logic run_init;     // reset flags, seed source, load counters
    logic read_issue;   // issue vertex store reads
    logic edge_latch;   // capture edge word, issue distance reads
    logic relax;        // relax current edge, advance counters
    logic out_zero;     // post an all-zero result
    logic out_read;     // post read result
  } bfsp_cmd_t;

  typedef struct packed {
    logic run_go;
    logic last_edge;
    logic last_round;
  } bfsp_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bfsp_ram.sv
// ----------------------------------------------------------------------------
// bfsp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bfsp_datapath.sv
// ----------------------------------------------------------------------------
// bfsp_datapath: edge store, vertex stores and relaxation arithmetic
// Holds the edge list, distances, predecessors, reached flags, the pass
// counters and the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfsp_datapath
  import bfsp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire bfsp_cmd_t                cmd,
  output bfsp_stat_t                    stat,
  input  wire logic                     config_we,
  input  wire logic [VTX_W-1:0]         config_data,
  input  wire logic [VTX_W-1:0]         from_vertex,
  input  wire logic [VTX_W-1:0]         to_vertex,
  input  wire logic signed [WT_W-1:0]   weight,
  input  wire logic [VTX_W-1:0]         vertex,
  output logic                          status,
  output logic signed [DIST_W-1:0]      distance,
  output logic [VTX_W-1:0]              predecessor,
  output logic                          reachable
);

  localparam logic [VTX_W-1:0]  VMAX   = VTX_W'(MAX_VERTICES);
  localparam logic [ECNT_W-1:0] EFULL  = ECNT_W'(MAX_EDGES);
  localparam logic [DIST_W-1:0] D_MAX  = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] D_MIN  = {1'b1, {(DIST_W-1){1'b0}}};

  logic [VTX_W-1:0]    vertex_count;
  logic [VTX_W-1:0]    n_act;
  logic [ECNT_W-1:0]   edge_count;
  logic [EA_W-1:0]     edge_idx;
  logic [VTX_W-1:0]    rounds_left;
  logic [MAX_VERTICES:0] flags;

  logic [EDGE_W-1:0]   edge_rdata;
  logic [VTX_W-1:0]    e_tail, e_head;
  logic [WEIGHT_BITS-1:0] e_wt;

  logic [VTX_W-1:0]    tail_r, head_r;
  logic [WEIGHT_BITS-1:0] wt_r;
  logic                edge_ok_r;

  logic [DIST_W-1:0]   dist_t, dist_h;
  logic [VTX_W-1:0]    pred_rdata;
  logic                read_ok_r;

  logic                full;
  logic                src_ok, tail_ok, head_ok, rd_ok;
  logic [DIST_W:0]     sum;
  logic [DIST_W-1:0]   cand;
  logic                take;

  logic                dwe;
  logic [VTX_W-1:0]    dwaddr;
  logic [DIST_W-1:0]   dwdata;
  logic [VTX_W-1:0]    pwdata;
  logic [VTX_W-1:0]    dh_raddr;

  // clamp vertex count to 1..MAX_VERTICES
  always_comb begin
    if (vertex_count == '0) begin
      n_act = VTX_W'(1);
    end else if (vertex_count > VMAX) begin
      n_act = VMAX;
    end else begin
      n_act = vertex_count;
    end
  end

  assign full = (edge_count == EFULL);
  assign {e_tail, e_head, e_wt} = edge_rdata;

  assign src_ok  = (vertex != '0) && (vertex <= n_act);
  assign rd_ok   = src_ok && flags[vertex];
  assign tail_ok = (e_tail != '0) && (e_tail <= n_act);
  assign head_ok = (e_head != '0) && (e_head <= n_act);

  assign stat.run_go     = src_ok && (n_act != VTX_W'(1)) && (edge_count != '0);
  assign stat.last_edge  = ((ECNT_W'(edge_idx) + ECNT_W'(1)) == edge_count);
  assign stat.last_round = (rounds_left == VTX_W'(1));

  // saturating candidate distance
  assign sum  = {dist_t[DIST_W-1], dist_t}
              + {{(DIST_W+1-WEIGHT_BITS){wt_r[WEIGHT_BITS-1]}}, wt_r};
  assign cand = (sum[DIST_W] != sum[DIST_W-1]) ? (sum[DIST_W] ? D_MIN : D_MAX)
                                               : sum[DIST_W-1:0];
  assign take = edge_ok_r && (!flags[head_r] || ($signed(cand) < $signed(dist_h)));

  // vertex store write port: seed the source on run start, else relax
  always_comb begin
    dwe    = 1'b0;
    dwaddr = head_r;
    dwdata = cand;
    pwdata = tail_r;
    if (cmd.run_init) begin
      dwe    = src_ok;
      dwaddr = vertex;
      dwdata = '0;
      pwdata = '0;
    end else if (cmd.relax) begin
      dwe    = take;
    end
  end

  assign dh_raddr = cmd.read_issue ? vertex : e_head;

  bfsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (cmd.load_edge && !full),
    .waddr (edge_count[EA_W-1:0]),
    .wdata ({from_vertex, to_vertex, weight[WEIGHT_BITS-1:0]}),
    .raddr (edge_idx),
    .rdata (edge_rdata)
  );

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(VDEPTH)) u_dist_tail_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (dwaddr),
    .wdata (dwdata),
    .raddr (e_tail),
    .rdata (dist_t)
  );

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(VDEPTH)) u_dist_head_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (dwaddr),
    .wdata (dwdata),
    .raddr (dh_raddr),
    .rdata (dist_h)
  );

  bfsp_ram #(.WIDTH(VTX_W), .DEPTH(VDEPTH)) u_pred_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (dwaddr),
    .wdata (pwdata),
    .raddr (vertex),
    .rdata (pred_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VTX_W'(1);
      edge_count   <= '0;
      flags        <= '0;
      edge_idx     <= '0;
      rounds_left  <= '0;
    end else begin
      if (config_we) begin
        vertex_count <= config_data;
      end
      if (cmd.load_edge && !full) begin
        edge_count <= edge_count + ECNT_W'(1);
      end
      if (cmd.clear_edges) begin
        edge_count <= '0;
      end
      if (cmd.run_init) begin
        // drop all reached marks, keep only the source
        flags       <= src_ok ? (VDEPTH'(1) << vertex) : '0;
        edge_idx    <= '0;
        rounds_left <= n_act - VTX_W'(1);
      end else if (cmd.relax) begin
        if (take) begin
          flags[head_r] <= 1'b1;
        end
        // wrap to the first edge at the end of a pass
        if (stat.last_edge) begin
          edge_idx    <= '0;
          rounds_left <= rounds_left - VTX_W'(1);
        end else begin
          edge_idx <= edge_idx + EA_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_latch) begin
      tail_r    <= e_tail;
      head_r    <= e_head;
      wt_r      <= e_wt;
      edge_ok_r <= tail_ok && head_ok && flags[e_tail];
    end
    if (cmd.read_issue) begin
      read_ok_r <= rd_ok;
    end
    if (cmd.load_edge) begin
      status      <= full;
      distance    <= '0;
      predecessor <= '0;
      reachable   <= 1'b0;
    end else if (cmd.out_zero || cmd.clear_edges) begin
      status      <= 1'b0;
      distance    <= '0;
      predecessor <= '0;
      reachable   <= 1'b0;
    end else if (cmd.out_read) begin
      status      <= 1'b0;
      distance    <= read_ok_r ? dist_h : '0;
      predecessor <= read_ok_r ? pred_rdata : '0;
      reachable   <= read_ok_r;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bfsp_ctrl.sv
// ----------------------------------------------------------------------------
// bfsp_ctrl: sequencer of the shortest-path block
// Decodes operations and steps edge relaxation through read, latch and
// relax phases; drives the done strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfsp_ctrl
  import bfsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  operation,
  input  wire bfsp_stat_t  stat,
  output bfsp_cmd_t        cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EDGE  = 5'b00100,
    S_VERT  = 5'b01000,
    S_RELAX = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (operation)
            OP_ADD: begin
              cmd.load_edge = 1'b1;
              done_next     = 1'b1;
            end
            OP_CLEAR: begin
              cmd.clear_edges = 1'b1;
              done_next       = 1'b1;
            end
            OP_RUN: begin
              cmd.run_init = 1'b1;
              if (stat.run_go) begin
                state_next = S_EDGE;
              end else begin
                cmd.out_zero = 1'b1;
                done_next    = 1'b1;
              end
            end
            OP_READ: begin
              cmd.read_issue = 1'b1;
              state_next     = S_READ;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.out_read = 1'b1;
        done_next    = 1'b1;
        state_next   = S_IDLE;
      end
      S_EDGE: begin
        state_next = S_VERT;
      end
      S_VERT: begin
        cmd.edge_latch = 1'b1;
        state_next     = S_RELAX;
      end
      S_RELAX: begin
        cmd.relax = 1'b1;
        if (stat.last_edge && stat.last_round) begin
          cmd.out_zero = 1'b1;
          done_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_EDGE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bellman_ford_shortest_path.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path: single-source shortest path engine
// Loads directed weighted edges, relaxes them from a source vertex and
// returns distance, predecessor and reachability of any vertex.
// ----------------------------------------------------------------------------
// Usage:
//   An operation beat is taken on a clock edge with start high and busy low.
//   Each operation produces exactly one result beat, shown for one cycle
//   with done high; the receiver cannot stall it.
//   Add edge and clear: result in the cycle after the beat, busy stays low, so
//   a new beat may follow in the next cycle.
//   Read vertex: the store reads are registered, then S_READ posts the result.
//   Run: (vertex_count - 1) passes over the edge list; each edge takes an
//   edge store read, a distance store read and a relax/write step. A run
//   that cannot relax anything gives its result in the cycle after the beat.
//   config_we writes vertex_count; write it only while idle.
//   Reset (rst, synchronous) empties the edge list, clears reached flags and
//   sets vertex_count to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bellman_ford_shortest_path
  import bfsp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     config_we,
  input  wire logic [VTX_W-1:0]         config_data,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               operation,
  input  wire logic [VTX_W-1:0]         from_vertex,
  input  wire logic [VTX_W-1:0]         to_vertex,
  input  wire logic signed [WT_W-1:0]   weight,
  input  wire logic [VTX_W-1:0]         vertex,
  output logic                          done,
  output logic                          status,
  output logic signed [DIST_W-1:0]      distance,
  output logic [VTX_W-1:0]              predecessor,
  output logic                          reachable
);

  bfsp_cmd_t  cmd;
  bfsp_stat_t stat;

  bfsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  bfsp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .config_we   (config_we),
    .config_data (config_data),
    .from_vertex (from_vertex),
    .to_vertex   (to_vertex),
    .weight      (weight),
    .vertex      (vertex),
    .status      (status),
    .distance    (distance),
    .predecessor (predecessor),
    .reachable   (reachable)
  );

endmodule
`default_nettype wire
